// ----- sv/sorted_coordinate_table_defines.svh -----
// ----------------------------------------------------------------------------
// sorted coordinate table assertion macros
// shared property wrappers for the clocked checks of the table
// ----------------------------------------------------------------------------
`ifndef SORTED_COORDINATE_TABLE_DEFINES_SVH
`define SORTED_COORDINATE_TABLE_DEFINES_SVH

// condition that must hold at every edge out of reset
`define SCT_ASSERT_HOLD(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sorted coordinate table package
// sizes, command codes, state type and key helpers shared by the table
// ----------------------------------------------------------------------------
package sct_pkg;

    // table size and derived widths
    localparam int CAPACITY    = 256;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int COORD_W     = 16;
    localparam int KEY_W       = 2 * COORD_W;
    localparam int CMD_W       = 2;
    localparam int OUT_W       = 9;
    localparam int IN_TDATA_W  = ((CMD_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 3 + 2 * OUT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ROW    = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_COMMIT = 1'b1
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic capture;  // register order flags against the incoming word
        logic row;      // compare on y only
        logic shift;    // open a slot and insert
        logic clear;    // drop all entries
    } t_cell_ctrl;

    // signed y then signed x, as one unsigned order key
    function automatic t_key order_key(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y);
        logic [COORD_W-1:0] msb;
        msb = {1'b1, {(COORD_W-1){1'b0}}};
        return {y ^ msb, x ^ msb};
    endfunction

endpackage

// ----- sv/sct_cell.sv -----
// ----------------------------------------------------------------------------
// sorted coordinate table cell
// holds one entry, compares it with the incoming word and shifts up on insert
// ----------------------------------------------------------------------------
module sct_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sct_pkg::t_cell_ctrl i_ctrl,
    input  sct_pkg::t_key      i_cmp_key,   // key of the word being accepted
    input  sct_pkg::t_key      i_ins_key,   // key of the word being committed
    input  logic               i_prev_lt,
    input  logic               i_prev_valid,
    input  sct_pkg::t_key      i_prev_key,
    output logic               o_lt,
    output logic               o_valid,
    output sct_pkg::t_key      o_key,
    output logic               o_match
);
    import sct_pkg::*;

    logic r_valid;
    logic r_lt;
    logic r_eq;
    t_key r_key;
    logic w_lt;
    logic w_eq;

    // order compare, full key or row only
    always_comb begin
        if (i_ctrl.row) begin
            w_lt = r_key[KEY_W-1:COORD_W] < i_cmp_key[KEY_W-1:COORD_W];
            w_eq = r_key[KEY_W-1:COORD_W] == i_cmp_key[KEY_W-1:COORD_W];
        end else begin
            w_lt = r_key < i_cmp_key;
            w_eq = r_key == i_cmp_key;
        end
    end

    // flags and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctrl.capture) begin
                r_lt <= r_valid & w_lt;
                r_eq <= r_valid & w_eq;
            end
            if (i_ctrl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctrl.shift && !r_lt) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    // entry payload: keep, take the new word or take the neighbour's entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift && !r_lt) begin
            if (i_prev_lt) begin
                r_key <= i_ins_key;
            end else begin
                r_key <= i_prev_key;
            end
        end
    end

    assign o_lt    = r_lt;
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_match = r_eq;

endmodule

// ----- sv/sct_encode.sv -----
// ----------------------------------------------------------------------------
// sorted coordinate table position encoder
// turns the chain's below-key thermometer into a rank
// ----------------------------------------------------------------------------
module sct_encode (
    input  logic [sct_pkg::CAPACITY-1:0] i_therm,
    output sct_pkg::t_cnt                o_rank
);
    import sct_pkg::*;

    logic [CAPACITY+1:0] w_ext;

    // a one in front, a zero behind, so exactly one step exists
    assign w_ext = {1'b0, i_therm, 1'b1};

    // or together the index of the single one-to-zero step
    always_comb begin
        o_rank = '0;
        for (int i = 0; i <= CAPACITY; i++) begin
            if (w_ext[i] && !w_ext[i+1]) begin
                o_rank = o_rank | CNT_W'(i);
            end
        end
    end

endmodule

// ----- sv/sorted_coordinate_table.sv -----
// ----------------------------------------------------------------------------
// sorted coordinate table
// bounded set of distinct (x,y) points kept sorted by y then x in a cell chain
// ----------------------------------------------------------------------------
// In the cycle a word is accepted each cell of the chain compares its entry
// with the word and registers below and equal flags; in the commit state that
// follows, the position encoder resolves the rank from those flags, the
// result word is loaded and, for an insert, every cell at or above the rank
// shifts its entry up by one in the same cycle. No new word is taken until
// the commit is done; a held result holds the commit cycle, and with it the
// input, until the result is taken. The table is empty after reset, with no
// clearing pass; a clear command empties it in its commit cycle.
`include "sorted_coordinate_table_defines.svh"

module sorted_coordinate_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command, coord_x, coord_y
    input  logic [sct_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // found, inserted, full_res, position, entry_count
    output logic [sct_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready
);
    import sct_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    t_key                r_key;
    t_cnt                r_cnt;
    t_cnt                n_cnt;
    logic                r_out_valid;
    logic [OUT_FIELD_W-1:0] r_out;

    t_cmd                w_in_cmd;
    t_key                w_in_key;
    logic                w_accept;
    logic                w_commit;
    logic                w_out_free;
    logic                w_found;
    logic                w_full;
    logic                w_insert;
    logic                w_refuse;
    t_cnt                w_rank;
    logic [OUT_W-1:0]    w_pos_out;
    t_cell_ctrl          w_ctrl;

    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_match;
    t_key                w_key [CAPACITY];

    // input word unpacking
    assign w_in_cmd = t_cmd'(i_s_tdata[CMD_W-1:0]);
    assign w_in_key = order_key(i_s_tdata[CMD_W +: COORD_W],
                                i_s_tdata[CMD_W+COORD_W +: COORD_W]);

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = ST_COMMIT;
            ST_COMMIT: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            ST_IDLE:   o_s_tready = 1'b1;
            ST_COMMIT: w_commit   = w_out_free;
            default:   o_s_tready = 1'b0;
        endcase
    end

    // command decisions in the commit cycle
    assign w_found  = |(w_match & w_valid);
    assign w_full   = r_cnt == t_cnt'(CAPACITY);
    assign w_insert = w_commit && (r_cmd == CMD_INSERT) && !w_found && !w_full;
    assign w_refuse = (r_cmd == CMD_INSERT) && !w_found && w_full;

    assign w_ctrl.capture = w_accept;
    assign w_ctrl.row     = w_in_cmd == CMD_ROW;
    assign w_ctrl.shift   = w_insert;
    assign w_ctrl.clear   = w_commit && (r_cmd == CMD_CLEAR);

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic w_prev_lt;
        logic w_prev_valid;
        t_key w_prev_key;
        if (g == 0) begin : g_head
            assign w_prev_lt    = 1'b1;
            assign w_prev_valid = 1'b1;
            assign w_prev_key   = '0;
        end else begin : g_link
            assign w_prev_lt    = w_lt[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_key   = w_key[g-1];
        end
        sct_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_cmp_key    (w_in_key),
            .i_ins_key    (r_key),
            .i_prev_lt    (w_prev_lt),
            .i_prev_valid (w_prev_valid),
            .i_prev_key   (w_prev_key),
            .o_lt         (w_lt[g]),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g]),
            .o_match      (w_match[g])
        );
    end

    // rank from the below-key flags
    sct_encode u_encode (
        .i_therm (w_lt),
        .o_rank  (w_rank)
    );

    // entry count after the command
    always_comb begin
        n_cnt = r_cnt;
        if (w_commit && (r_cmd == CMD_CLEAR)) begin
            n_cnt = '0;
        end else if (w_insert) begin
            n_cnt = r_cnt + t_cnt'(1);
        end
    end

    assign w_pos_out = (r_cmd == CMD_CLEAR) ? '0 : OUT_W'(w_rank);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // accepted word and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_in_cmd;
            r_key <= w_in_key;
        end
        if (w_commit) begin
            r_out <= {OUT_W'(n_cnt), w_pos_out,
                      w_refuse, w_insert,
                      w_found && (r_cmd != CMD_CLEAR)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out);

    // checks
    `SCT_ASSERT_HOLD(a_cnt_bound, r_cnt <= t_cnt'(CAPACITY), "entry count above capacity")
    `SCT_ASSERT_HOLD(a_valid_cnt, $countones(w_valid) == int'(r_cnt), "occupancy differs from count")
    `SCT_ASSERT_NEXT(a_insert_grow, w_insert, r_cnt == $past(r_cnt) + t_cnt'(1), "insert did not grow table")
    `SCT_ASSERT_HOLD(a_ins_refuse, !(r_out_valid && r_out[1] && r_out[2]), "inserted and refused together")

endmodule
